// ----- rtl/m4et_pkg.sv -----
// Shared types, constants and command/status structs for the power-4 multibrot block.
`default_nettype none
package m4et_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int ITER_BITS_DEF = 10;
  localparam int IN_FRAC = 28;
  localparam int IN_W = 31;
  localparam int DATA_W = 64;
  localparam int SAT_BIT = 60;
  localparam int ESC_W = 10;
  localparam int COLOR_W = 8;
  localparam int MAX_ITER_RESET = 100;
  localparam int ESCAPE_RADIUS_SQ = 16;
  localparam int RED_MUL = 10;
  localparam int GREEN_MUL = 13;
  localparam int BLUE_MUL = 15;
  localparam int COLOR_MOD = 255;

  localparam logic [SAT_BIT:0] PROD_LIMIT = {1'b1, {SAT_BIT{1'b0}}};

  typedef enum logic [2:0] {
    OP_XY,
    OP_AA,
    OP_BB,
    OP_AB,
    OP_XX,
    OP_YY
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_XY,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_MUL_AB,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_TEST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic init;
    op_t  op;
    logic mul_start;
    logic mul_store;
    logic test;
    logic iter_inc;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic iter_end;
    logic escape;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/m4et_fxmul.sv -----
// Multi-cycle signed fixed-point multiplier with floor shift and saturation.
`default_nettype none
module m4et_fxmul #(
  parameter int FRAC_BITS = m4et_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [m4et_pkg::DATA_W-1:0] op_a,
  input  wire logic signed [m4et_pkg::DATA_W-1:0] op_b,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [m4et_pkg::DATA_W-1:0]      result
);

  localparam int DW = m4et_pkg::DATA_W;
  localparam int HALF = DW / 2;
  localparam int ACC_W = 2 * DW;
  localparam int SB = m4et_pkg::SAT_BIT;
  localparam logic [2:0] CNT_LAST_PP = 3'd3;
  localparam logic [2:0] CNT_LAST_ACC = 3'd4;
  localparam logic [2:0] CNT_FIN = 3'd5;

  logic [DW-1:0]     ma;
  logic [DW-1:0]     mb;
  logic              neg;
  logic [2:0]        cnt;
  logic [DW-1:0]     pp;
  logic [1:0]        pp_sh;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [HALF-1:0]   half_a;
  logic [HALF-1:0]   half_b;
  logic              sat;
  logic [SB:0]       q;
  logic [SB+1:0]     qr;
  logic              rnd;
  logic [SB:0]       qv;
  logic [DW-1:0]     res_mag;

  function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  always_comb begin
    half_a = cnt[0] ? ma[DW-1:HALF] : ma[HALF-1:0];
    half_b = cnt[1] ? mb[DW-1:HALF] : mb[HALF-1:0];
    case (pp_sh)
      2'd0:    acc_next = acc + ACC_W'(pp);
      2'd1:    acc_next = acc + (ACC_W'(pp) << HALF);
      2'd2:    acc_next = acc + (ACC_W'(pp) << (2 * HALF));
      default: acc_next = acc;
    endcase
  end

  always_comb begin
    sat = |acc[ACC_W-1:SB+1+FRAC_BITS];
    q = acc[SB+FRAC_BITS:FRAC_BITS];
    rnd = neg && (|acc[FRAC_BITS-1:0]);
    qr = {1'b0, q} + {{(SB+1){1'b0}}, rnd};
    if (sat || (qr > {1'b0, m4et_pkg::PROD_LIMIT})) begin
      qv = m4et_pkg::PROD_LIMIT;
    end else begin
      qv = qr[SB:0];
    end
    res_mag = DW'(qv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= 3'd0;
      end else if (busy) begin
        if (cnt == CNT_FIN) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ma <= magnitude(op_a);
      mb <= magnitude(op_b);
      neg <= op_a[DW-1] ^ op_b[DW-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt <= CNT_LAST_PP) begin
        pp <= DW'(half_a) * DW'(half_b);
        pp_sh <= 2'(cnt[0]) + 2'(cnt[1]);
      end
      if ((cnt != 3'd0) && (cnt <= CNT_LAST_ACC)) begin
        acc <= acc_next;
      end
      if (cnt == CNT_FIN) begin
        result <= neg ? -$signed(res_mag) : $signed(res_mag);
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held for more than one cycle");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && ($past(cnt) == CNT_FIN)))
    else $error("multiplier done without a finalize step");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) busy |-> (cnt <= CNT_FIN))
    else $error("multiplier step counter out of range");

endmodule
`default_nettype wire

// ----- rtl/m4et_datapath.sv -----
// Datapath: iterate registers, shared multiplier, escape test, color and output register.
`default_nettype none
module m4et_datapath #(
  parameter int FRAC_BITS = m4et_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS = m4et_pkg::ITER_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [ITER_BITS-1:0]                 cfg_data,
  input  wire logic signed [m4et_pkg::IN_W-1:0]     c_real,
  input  wire logic signed [m4et_pkg::IN_W-1:0]     c_imag,
  input  wire m4et_pkg::ctrl_cmd_t                  cmd,
  output m4et_pkg::dp_status_t                      status,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [m4et_pkg::ESC_W-1:0]                escape_index,
  output logic [m4et_pkg::COLOR_W-1:0]              red,
  output logic [m4et_pkg::COLOR_W-1:0]              green,
  output logic [m4et_pkg::COLOR_W-1:0]              blue
);

  localparam int DW = m4et_pkg::DATA_W;
  localparam int SHL = (FRAC_BITS >= m4et_pkg::IN_FRAC) ? FRAC_BITS - m4et_pkg::IN_FRAC : 0;
  localparam int SHR = (FRAC_BITS >= m4et_pkg::IN_FRAC) ? 0 : m4et_pkg::IN_FRAC - FRAC_BITS;
  localparam logic signed [DW-1:0] LIMIT = DW'(m4et_pkg::ESCAPE_RADIUS_SQ) <<< FRAC_BITS;
  localparam int PW = 24;

  logic [ITER_BITS-1:0]   max_iter;
  logic [ITER_BITS-1:0]   iter;
  logic                   escaped;
  logic signed [DW-1:0]   cr;
  logic signed [DW-1:0]   ci;
  logic signed [DW-1:0]   x;
  logic signed [DW-1:0]   y;
  logic signed [DW-1:0]   a;
  logic signed [DW-1:0]   b;
  logic signed [DW-1:0]   paa;
  logic signed [DW-1:0]   pbb;
  logic signed [DW-1:0]   sqx;
  logic signed [DW-1:0]   sqy;
  logic signed [DW-1:0]   op_a;
  logic signed [DW-1:0]   op_b;
  logic signed [DW-1:0]   res;
  logic signed [DW-1:0]   cr_in;
  logic signed [DW-1:0]   ci_in;
  logic                   mul_busy;
  logic                   mul_done;
  logic [ITER_BITS-1:0]   idx_v;
  logic [31:0]            idx_wide;

  function automatic logic [m4et_pkg::COLOR_W-1:0] color(input logic [ITER_BITS-1:0] idx,
                                                         input int k);
    logic [PW-1:0] p;
    logic [9:0]    s;
    logic [8:0]    t;
    p = PW'(idx) * PW'(k);
    s = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
    t = 9'(s[7:0]) + 9'(s[9:8]);
    if (t >= 9'(m4et_pkg::COLOR_MOD)) begin
      t = t - 9'(m4et_pkg::COLOR_MOD);
    end
    return t[m4et_pkg::COLOR_W-1:0];
  endfunction

  assign cr_in = (DW'(c_real) <<< SHL) >>> SHR;
  assign ci_in = (DW'(c_imag) <<< SHL) >>> SHR;

  always_comb begin
    case (cmd.op)
      m4et_pkg::OP_XY: begin
        op_a = x;
        op_b = y;
      end
      m4et_pkg::OP_AA: begin
        op_a = a;
        op_b = a;
      end
      m4et_pkg::OP_BB: begin
        op_a = b;
        op_b = b;
      end
      m4et_pkg::OP_AB: begin
        op_a = a;
        op_b = b;
      end
      m4et_pkg::OP_XX: begin
        op_a = x;
        op_b = x;
      end
      m4et_pkg::OP_YY: begin
        op_a = y;
        op_b = y;
      end
      default: begin
        op_a = x;
        op_b = y;
      end
    endcase
  end

  m4et_fxmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fxmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .op_a   (op_a),
    .op_b   (op_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (res)
  );

  always_comb begin
    status.mul_busy = mul_busy;
    status.mul_done = mul_done;
    status.iter_end = (iter >= max_iter);
    status.escape = ((sqx + sqy) > LIMIT);
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= ITER_BITS'(m4et_pkg::MAX_ITER_RESET);
    end else if (cfg_we) begin
      max_iter <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cr <= cr_in;
      ci <= ci_in;
      x <= '0;
      y <= '0;
      sqx <= '0;
      sqy <= '0;
      iter <= '0;
      escaped <= 1'b0;
    end else begin
      if (cmd.mul_store) begin
        case (cmd.op)
          m4et_pkg::OP_XY: begin
            a <= sqx - sqy;
            b <= res <<< 1;
          end
          m4et_pkg::OP_AA: paa <= res;
          m4et_pkg::OP_BB: pbb <= res;
          m4et_pkg::OP_AB: begin
            x <= paa - pbb + cr;
            y <= (res <<< 1) + ci;
          end
          m4et_pkg::OP_XX: sqx <= res;
          m4et_pkg::OP_YY: sqy <= res;
          default: ;
        endcase
      end
      if (cmd.test && status.escape) begin
        escaped <= 1'b1;
      end
      if (cmd.iter_inc) begin
        iter <= iter + ITER_BITS'(1);
      end
    end
  end

  assign idx_v = escaped ? iter : '0;
  assign idx_wide = 32'(idx_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      escape_index <= idx_wide[m4et_pkg::ESC_W-1:0];
      red <= color(idx_v, m4et_pkg::RED_MUL);
      green <= color(idx_v, m4et_pkg::GREEN_MUL);
      blue <= color(idx_v, m4et_pkg::BLUE_MUL);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/m4et_ctrl.sv -----
// Controller state machine that sequences the products of each iteration.
`default_nettype none
module m4et_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire m4et_pkg::dp_status_t status,
  output m4et_pkg::ctrl_cmd_t       cmd
);

  m4et_pkg::state_t state;
  m4et_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4et_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      m4et_pkg::ST_IDLE:   if (in_valid) state_next = m4et_pkg::ST_CHECK;
      m4et_pkg::ST_CHECK: begin
        state_next = status.iter_end ? m4et_pkg::ST_FINISH : m4et_pkg::ST_MUL_XY;
      end
      m4et_pkg::ST_MUL_XY: if (status.mul_done) state_next = m4et_pkg::ST_MUL_AA;
      m4et_pkg::ST_MUL_AA: if (status.mul_done) state_next = m4et_pkg::ST_MUL_BB;
      m4et_pkg::ST_MUL_BB: if (status.mul_done) state_next = m4et_pkg::ST_MUL_AB;
      m4et_pkg::ST_MUL_AB: if (status.mul_done) state_next = m4et_pkg::ST_MUL_XX;
      m4et_pkg::ST_MUL_XX: if (status.mul_done) state_next = m4et_pkg::ST_MUL_YY;
      m4et_pkg::ST_MUL_YY: if (status.mul_done) state_next = m4et_pkg::ST_TEST;
      m4et_pkg::ST_TEST: begin
        state_next = status.escape ? m4et_pkg::ST_FINISH : m4et_pkg::ST_CHECK;
      end
      m4et_pkg::ST_FINISH: if (status.out_free) state_next = m4et_pkg::ST_IDLE;
      default:             state_next = m4et_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    cmd.op = m4et_pkg::OP_XY;
    case (state)
      m4et_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.init = in_valid;
      end
      m4et_pkg::ST_MUL_XY, m4et_pkg::ST_MUL_AA, m4et_pkg::ST_MUL_BB,
      m4et_pkg::ST_MUL_AB, m4et_pkg::ST_MUL_XX, m4et_pkg::ST_MUL_YY: begin
        case (state)
          m4et_pkg::ST_MUL_AA: cmd.op = m4et_pkg::OP_AA;
          m4et_pkg::ST_MUL_BB: cmd.op = m4et_pkg::OP_BB;
          m4et_pkg::ST_MUL_AB: cmd.op = m4et_pkg::OP_AB;
          m4et_pkg::ST_MUL_XX: cmd.op = m4et_pkg::OP_XX;
          m4et_pkg::ST_MUL_YY: cmd.op = m4et_pkg::OP_YY;
          default:             cmd.op = m4et_pkg::OP_XY;
        endcase
        cmd.mul_start = !status.mul_busy && !status.mul_done;
        cmd.mul_store = status.mul_done;
      end
      m4et_pkg::ST_TEST: begin
        cmd.test = 1'b1;
        cmd.iter_inc = !status.escape;
      end
      m4et_pkg::ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/multibrot4_escape_time.sv -----
// Top level: power-4 multibrot escape-time unit with stream ports and a limit register.
// Each request runs n iterations, n being at most max_iterations. Each iteration is six
// fixed-point products on one shared 32x32 multiplier, plus a check and an escape-test
// state. Throughput: one point at a time; the next request is taken once the result is
// in the output register. Reset is synchronous and sets max_iterations to 100, output
// empty.
`default_nettype none
module multibrot4_escape_time #(
  parameter int FRAC_BITS = m4et_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS = m4et_pkg::ITER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [ITER_BITS-1:0] cfg_data,       // max_iterations
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [63:0]          s_axis_tdata,   // c_real[30:0], c_imag[61:31]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [39:0]               m_axis_tdata    // escape_index[9:0], red, green, blue
);

  localparam int IW = m4et_pkg::IN_W;
  localparam int EW = m4et_pkg::ESC_W;
  localparam int CW = m4et_pkg::COLOR_W;

  m4et_pkg::ctrl_cmd_t  cmd;
  m4et_pkg::dp_status_t status;
  logic [EW-1:0]        escape_index;
  logic [CW-1:0]        red;
  logic [CW-1:0]        green;
  logic [CW-1:0]        blue;
  logic signed [IW-1:0] c_real;
  logic signed [IW-1:0] c_imag;

  assign cfg_ready = 1'b1;
  assign c_real = s_axis_tdata[IW-1:0];
  assign c_imag = s_axis_tdata[2*IW-1:IW];
  assign m_axis_tdata = {6'b0, blue, green, red, escape_index};

  m4et_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  m4et_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .ITER_BITS(ITER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .c_real       (c_real),
    .c_imag       (c_imag),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .escape_index (escape_index),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule
`default_nettype wire
